>>> rtl/sm4_pkg.sv
// Shared types, constants and round functions for the SM4 block cipher.
// Used by sm4_ctrl, sm4_datapath and sm4_block_cipher; depends on nothing.
package sm4_pkg;

  localparam int WORD_W      = 32;
  localparam int HALF_W      = 64;
  localparam int NUM_ROUNDS  = 32;
  localparam int RK_IDX_W    = $clog2(NUM_ROUNDS);
  localparam int CFG_INDEX_W = 8;

  localparam logic [RK_IDX_W-1:0] LAST_ROUND = RK_IDX_W'(NUM_ROUNDS - 1);

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = CFG_INDEX_W'(1);

  localparam logic [WORD_W-1:0] FK [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FETCH,
    ST_ROUND,
    ST_FINISH
  } sm4_state_t;

  typedef struct packed {
    logic                key_load;
    logic                blk_load;
    logic                step;
    logic                key_mode;
    logic                out_load;
    logic [RK_IDX_W-1:0] idx;
    logic [RK_IDX_W-1:0] rd_idx;
  } sm4_cmd_t;

  typedef struct packed {
    logic stale;
  } sm4_sts_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [WORD_W-1:0] lin_round(input logic [WORD_W-1:0] v);
    return v ^ rotl(v, 2) ^ rotl(v, 10) ^ rotl(v, 18) ^ rotl(v, 24);
  endfunction

  function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] v);
    return v ^ rotl(v, 13) ^ rotl(v, 23);
  endfunction

  // Byte j of CK[i] is 7 * (4i + j) modulo 256.
  function automatic logic [WORD_W-1:0] chain_const(input logic [RK_IDX_W-1:0] i);
    logic [WORD_W-1:0] w;
    logic [7:0]        pos;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      pos = {1'b0, i, 2'(j)};
      w   = {w[WORD_W-9:0], 8'(pos * 8'd7)};
    end
    return w;
  endfunction

endpackage

>>> rtl/sm4_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the SM4 round keys in this design.
module sm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sm4_datapath.sv
// SM4 datapath: key registers, state words, shared round unit, round key RAM
// and output register. Depends on sm4_pkg and sm4_ram.
module sm4_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [sm4_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sm4_pkg::HALF_W-1:0]         cfg_data,
  input  logic [sm4_pkg::HALF_W-1:0]         block_high,
  input  logic [sm4_pkg::HALF_W-1:0]         block_low,
  input  logic                               decrypt,
  output logic [sm4_pkg::HALF_W-1:0]         output_high,
  output logic [sm4_pkg::HALF_W-1:0]         output_low,
  input  sm4_pkg::sm4_cmd_t                  cmd,
  output sm4_pkg::sm4_sts_t                  sts
);
  import sm4_pkg::*;

  logic [HALF_W-1:0]          key_high;
  logic [HALF_W-1:0]          key_low;
  logic                       stale;
  logic                       dec;
  logic [3:0][WORD_W-1:0]     x;
  logic [WORD_W-1:0]          rk;
  logic [WORD_W-1:0]          mix;
  logic [WORD_W-1:0]          sub;
  logic [WORD_W-1:0]          nx;
  logic [RK_IDX_W-1:0]        raddr;
  logic                       rk_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      stale    <= 1'b1;
    end else begin
      if (cmd.key_load) begin
        stale <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KEY_HIGH: begin
            key_high <= cfg_data;
            stale    <= 1'b1;
          end
          REG_KEY_LOW: begin
            key_low <= cfg_data;
            stale   <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign mix = x[1] ^ x[2] ^ x[3] ^ (cmd.key_mode ? chain_const(cmd.idx) : rk);
  assign sub = tau(mix);
  assign nx  = x[0] ^ (cmd.key_mode ? lin_key(sub) : lin_round(sub));

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      x[0] <= key_high[63:32] ^ FK[0];
      x[1] <= key_high[31:0]  ^ FK[1];
      x[2] <= key_low[63:32]  ^ FK[2];
      x[3] <= key_low[31:0]   ^ FK[3];
    end else if (cmd.blk_load) begin
      x[0] <= block_high[63:32];
      x[1] <= block_high[31:0];
      x[2] <= block_low[63:32];
      x[3] <= block_low[31:0];
      dec  <= decrypt;
    end else if (cmd.step) begin
      x <= {nx, x[3], x[2], x[1]};
    end
    if (cmd.out_load) begin
      output_high <= {x[3], x[2]};
      output_low  <= {x[1], x[0]};
    end
  end

  assign raddr = dec ? ~cmd.rd_idx : cmd.rd_idx;
  assign rk_we = cmd.step & cmd.key_mode;

  sm4_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_ROUNDS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (cmd.idx),
    .wdata (nx),
    .raddr (raddr),
    .rdata (rk)
  );

  assign sts.stale = stale;

endmodule

>>> rtl/sm4_ctrl.sv
// SM4 controller: sequences key expansion, block rounds and result hand-off.
// Depends on sm4_pkg.
module sm4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              block_valid,
  output logic              block_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  sm4_pkg::sm4_sts_t sts,
  output sm4_pkg::sm4_cmd_t cmd
);
  import sm4_pkg::*;

  sm4_state_t          state;
  sm4_state_t          state_next;
  logic [RK_IDX_W-1:0] cnt;
  logic [RK_IDX_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    block_stall = 1'b1;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        if (sts.stale) begin
          cmd.key_load = 1'b1;
          cnt_next     = '0;
          state_next   = ST_EXPAND;
        end else begin
          block_stall = 1'b0;
          if (block_valid) begin
            cmd.blk_load = 1'b1;
            state_next   = ST_FETCH;
          end
        end
      end
      ST_EXPAND: begin
        cmd.step     = 1'b1;
        cmd.key_mode = 1'b1;
        cmd.idx      = cnt;
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_ROUND) begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        cmd.rd_idx = '0;
        cnt_next   = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.step   = 1'b1;
        cmd.idx    = cnt;
        cmd.rd_idx = cnt + 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == LAST_ROUND) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && cnt == LAST_ROUND) |=> state == ST_FINISH)
    else $error("round sequence did not end in FINISH");

  a_fresh_keys: assert property (@(posedge clk) disable iff (rst)
    cmd.blk_load |-> !sts.stale)
    else $error("block started with stale round keys");

  a_result_set: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> result_valid)
    else $error("result register loaded without valid");

  a_expand_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && sts.stale) |=> state == ST_EXPAND)
    else $error("stale keys did not start expansion");

endmodule

>>> rtl/sm4_block_cipher.sv
// Top level of the SM4 block cipher: controller plus datapath.
// Depends on sm4_pkg, sm4_ctrl, sm4_datapath and sm4_ram.
//
//   Channel  Handshake                Payload
//   block    block_valid/block_stall  block_high, block_low, decrypt
//   result   result_valid/result_stall output_high, output_low
//   config   cfg_valid/cfg_ready      cfg_index, cfg_data (0 key_high, 1 key_low)
//
// A block goes from transfer to result through one round key fetch, 32 rounds
// on the shared round unit and the load of the output register.
// The next block is taken only after the previous one's result is in the output register.
// After reset and after every key write, key expansion runs before the
// next block transfer. Reset is synchronous; the round key RAM is not cleared.
// A stalled result holds in the output register while the next block is processed.
module sm4_block_cipher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            block_valid,
  output logic                            block_stall,
  input  logic [sm4_pkg::HALF_W-1:0]      block_high,
  input  logic [sm4_pkg::HALF_W-1:0]      block_low,
  input  logic                            decrypt,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [sm4_pkg::HALF_W-1:0]      output_high,
  output logic [sm4_pkg::HALF_W-1:0]      output_low,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sm4_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sm4_pkg::HALF_W-1:0]      cfg_data
);
  import sm4_pkg::*;

  sm4_cmd_t cmd;
  sm4_sts_t sts;

  assign cfg_ready = 1'b1;

  sm4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .block_valid  (block_valid),
    .block_stall  (block_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  sm4_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .block_high  (block_high),
    .block_low   (block_low),
    .decrypt     (decrypt),
    .output_high (output_high),
    .output_low  (output_low),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
